// ===== rtl/core/wskp_pkg.sv =====
// Shared widths, codes, state encoding and unit types of the window singleton k-th position core.
`default_nettype none

package wskp_pkg;

   // Field widths
   localparam int POS_W        = 12;
   localparam int VAL_W        = 12;
   localparam int CNT_W        = 13;
   localparam int RANK_W       = CNT_W;
   localparam int OP_W         = 2;

   // Storage geometry
   localparam int POSITIONS    = 1 << POS_W;
   localparam int VALUES       = 1 << VAL_W;
   localparam int BUCKET_SHIFT = 6;
   localparam int BKT_W        = POS_W - BUCKET_SHIFT;
   localparam int BUCKETS      = 1 << BKT_W;
   localparam int BUCKET_SIZE  = 1 << BUCKET_SHIFT;
   localparam int BCNT_W       = BUCKET_SHIFT + 1;
   localparam int VWORD_W      = CNT_W + POS_W;

   // Stream word widths
   localparam int REQ_DATA_W   = ((POS_W + VAL_W + RANK_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = ((POS_W + 7) / 8) * 8;

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

   // Operation codes carried in the request tuser
   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_RD,
      ST_UPD_CHK,
      ST_FLAG_RD,
      ST_FLAG_WR,
      ST_TOTAL,
      ST_Q_CHK,
      ST_Q_BKT,
      ST_Q_ROW,
      ST_Q_LOAD,
      ST_Q_BIT,
      ST_Q_OUT
   } state_type;

   // Operands and result of the shared add/subtract unit
   typedef struct packed {
      logic [CNT_W-1:0] a;
      logic [CNT_W-1:0] b;
      logic             sub;
   } alu_req_type;

   typedef struct packed {
      logic [CNT_W-1:0] sum;
      logic             carry;
      logic             zero;
   } alu_res_type;

endpackage

`default_nettype wire

// ===== rtl/core/wskp_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module wskp_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/wskp_alu.sv =====
// Shared add/subtract unit with borrow and zero flags used by the sequencer steps.
`default_nettype none

module wskp_alu (
   input  wire wskp_pkg::alu_req_type req,
   output wskp_pkg::alu_res_type      res
);
   import wskp_pkg::*;

   logic [CNT_W:0] wide;

   // Add, or subtract with borrow out in the top bit
   always_comb begin
      if (req.sub) begin
         wide = {1'b0, req.a} - {1'b0, req.b};
      end else begin
         wide = {1'b0, req.a} + {1'b0, req.b};
      end
      res.sum   = wide[CNT_W-1:0];
      res.carry = wide[CNT_W];
      res.zero  = (wide[CNT_W-1:0] == '0);
   end

endmodule

`default_nettype wire

// ===== rtl/core/window_singleton_kth_position_core.sv =====
// Top level: sequencer over value, flag and bucket memories for singleton k-th position queries.
//
//  channel  dir  fields (lowest bit first)
//  req      in   tuser: op[1:0]; tdata: position[11:0], value_id[23:12], rank[36:24], zero pad
//  rsp      out  tuser: found[0];  tdata: answer_position[11:0], zero pad
//
// After reset a clearing pass over all 4096 value entries zeroes the value, flag and bucket memories;
// req_tready stays low meanwhile.
// Add and remove read the value entry and step its count; when a singleton flag changes they
// also rewrite the flag row and bucket count and step the total, unless the flag already holds
// its new value (memory read-modify-write via the registered read ports and the shared unit).
// A query walks up to 64 bucket counts and then up to 64 flags of one row, one per cycle
// through the shared unit. A rejected rank goes straight to the output register.
// One item is in work at a time; a finished result waits in the output register and a new
// word is accepted meanwhile. A query result stalls only while that register is still full.
`default_nettype none

module window_singleton_kth_position_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [wskp_pkg::REQ_DATA_W-1:0] req_tdata,  // position, value_id, rank, pad
   input  wire logic [wskp_pkg::OP_W-1:0]       req_tuser,  // op
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [wskp_pkg::RSP_DATA_W-1:0] rsp_tdata,  // answer_position, pad
   output logic                                 rsp_tuser   // found
);
   import wskp_pkg::*;

   state_type state_ff, state_in;

   logic [OP_W-1:0]        op_ff, op_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [VAL_W-1:0]       val_ff, val_in;
   logic [CNT_W-1:0]       k_ff, k_in;
   logic [POS_W-1:0]       fpos_ff, fpos_in;
   logic                   fset_ff, fset_in;
   logic [BKT_W-1:0]       cur_ff, cur_in;
   logic [BUCKET_SHIFT-1:0] bit_ff, bit_in;
   logic [BUCKET_SIZE-1:0] row_ff, row_in;
   logic [CNT_W-1:0]       total_ff, total_in;
   logic [VAL_W-1:0]       clr_ff, clr_in;
   logic                   res_found_ff, res_found_in;
   logic [POS_W-1:0]       res_pos_ff, res_pos_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]       rsp_pos_ff, rsp_pos_in;

   // Memory ports
   logic                   v_wr_en;
   logic [VAL_W-1:0]       v_wr_addr;
   logic [VWORD_W-1:0]     v_wr_data;
   logic [VWORD_W-1:0]     v_rd_data;
   logic                   f_wr_en;
   logic [BKT_W-1:0]       f_wr_addr;
   logic [BUCKET_SIZE-1:0] f_wr_data;
   logic [BKT_W-1:0]       f_rd_addr;
   logic [BUCKET_SIZE-1:0] f_rd_data;
   logic                   b_wr_en;
   logic [BKT_W-1:0]       b_wr_addr;
   logic [BCNT_W-1:0]      b_wr_data;
   logic [BKT_W-1:0]       b_rd_addr;
   logic [BCNT_W-1:0]      b_rd_data;

   alu_req_type            alu_req;
   alu_res_type            alu_res;

   logic [CNT_W-1:0]       v_count;
   logic [POS_W-1:0]       v_xor;
   logic [BUCKET_SIZE-1:0] row_mod;

   assign v_count = v_rd_data[VWORD_W-1:POS_W];
   assign v_xor   = v_rd_data[POS_W-1:0];

   // Count and position XOR per value
   wskp_ram #(.WIDTH(VWORD_W), .DEPTH(VALUES)) u_value_ram (
      .clock   (clock),
      .wr_en   (v_wr_en),
      .wr_addr (v_wr_addr),
      .wr_data (v_wr_data),
      .rd_addr (val_ff),
      .rd_data (v_rd_data)
   );

   // Singleton flags, one row per bucket
   wskp_ram #(.WIDTH(BUCKET_SIZE), .DEPTH(BUCKETS)) u_flag_ram (
      .clock   (clock),
      .wr_en   (f_wr_en),
      .wr_addr (f_wr_addr),
      .wr_data (f_wr_data),
      .rd_addr (f_rd_addr),
      .rd_data (f_rd_data)
   );

   // Set flags per bucket
   wskp_ram #(.WIDTH(BCNT_W), .DEPTH(BUCKETS)) u_bucket_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (b_wr_data),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   wskp_alu u_alu (
      .req (alu_req),
      .res (alu_res)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-POS_W){1'b0}}, rsp_pos_ff};

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item operands and walk registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      k_ff         <= k_in;
      fpos_ff      <= fpos_in;
      fset_ff      <= fset_in;
      cur_ff       <= cur_in;
      bit_ff       <= bit_in;
      row_ff       <= row_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   // Sequencer: next state, unit operands and memory ports
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      k_in         = k_ff;
      fpos_in      = fpos_ff;
      fset_in      = fset_ff;
      cur_in       = cur_ff;
      bit_in       = bit_ff;
      row_in       = row_ff;
      total_in     = total_ff;
      clr_in       = clr_ff;
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;

      v_wr_en   = 1'b0;
      v_wr_addr = val_ff;
      v_wr_data = {alu_res.sum, v_xor ^ pos_ff};
      f_wr_en   = 1'b0;
      f_wr_addr = fpos_ff[POS_W-1:BUCKET_SHIFT];
      f_rd_addr = fpos_ff[POS_W-1:BUCKET_SHIFT];
      b_wr_en   = 1'b0;
      b_wr_addr = fpos_ff[POS_W-1:BUCKET_SHIFT];
      b_wr_data = alu_res.sum[BCNT_W-1:0];
      b_rd_addr = fpos_ff[POS_W-1:BUCKET_SHIFT];

      row_mod = f_rd_data;
      row_mod[fpos_ff[BUCKET_SHIFT-1:0]] = fset_ff;
      f_wr_data = row_mod;

      alu_req.a   = k_ff;
      alu_req.b   = CNT_W'(1);
      alu_req.sub = 1'b1;

      unique case (state_ff)
         ST_CLEAR: begin
            // Zero one entry of each memory per cycle
            v_wr_en   = 1'b1;
            v_wr_addr = clr_ff;
            v_wr_data = '0;
            f_wr_en   = 1'b1;
            f_wr_addr = clr_ff[BKT_W-1:0];
            f_wr_data = '0;
            b_wr_en   = 1'b1;
            b_wr_addr = clr_ff[BKT_W-1:0];
            b_wr_data = '0;
            clr_in    = clr_ff + VAL_W'(1);
            if (clr_ff == {VAL_W{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            // Take a word and dispatch on its op
            if (req_tvalid) begin
               op_in  = req_tuser;
               pos_in = req_tdata[POS_W-1:0];
               val_in = req_tdata[POS_W+VAL_W-1:POS_W];
               k_in   = req_tdata[POS_W+VAL_W+RANK_W-1:POS_W+VAL_W];
               cur_in = '0;
               case (req_tuser)
                  OP_ADD, OP_REMOVE: state_in = ST_UPD_RD;
                  OP_QUERY:          state_in = ST_Q_CHK;
                  default:           state_in = ST_IDLE;
               endcase
            end
         end

         ST_UPD_RD: begin
            // Value entry read is under way
            state_in = ST_UPD_CHK;
         end

         ST_UPD_CHK: begin
            // Step the count, fold the position into the XOR, pick the flag to touch
            alu_req.a   = v_count;
            alu_req.b   = CNT_W'(1);
            alu_req.sub = (op_ff == OP_REMOVE);
            if ((op_ff == OP_ADD && v_count == COUNT_MAX) ||
                (op_ff == OP_REMOVE && v_count == '0)) begin
               state_in = ST_IDLE;
            end else begin
               v_wr_en = 1'b1;
               if (v_count == CNT_W'(1)) begin
                  fpos_in  = v_xor;
                  fset_in  = 1'b0;
                  state_in = ST_FLAG_RD;
               end else if (alu_res.sum == CNT_W'(1)) begin
                  fpos_in  = v_xor ^ pos_ff;
                  fset_in  = 1'b1;
                  state_in = ST_FLAG_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_FLAG_RD: begin
            // Flag row and bucket count reads are under way
            state_in = ST_FLAG_WR;
         end

         ST_FLAG_WR: begin
            // Flip the flag and step its bucket count, unless already in place
            alu_req.a   = {{(CNT_W-BCNT_W){1'b0}}, b_rd_data};
            alu_req.b   = CNT_W'(1);
            alu_req.sub = !fset_ff;
            if (f_rd_data[fpos_ff[BUCKET_SHIFT-1:0]] == fset_ff) begin
               state_in = ST_IDLE;
            end else begin
               f_wr_en  = 1'b1;
               b_wr_en  = 1'b1;
               state_in = ST_TOTAL;
            end
         end

         ST_TOTAL: begin
            alu_req.a   = total_ff;
            alu_req.b   = CNT_W'(1);
            alu_req.sub = !fset_ff;
            total_in    = alu_res.sum;
            state_in    = ST_IDLE;
         end

         ST_Q_CHK: begin
            // Reject rank zero or above the total; start the bucket reads
            alu_req.a   = total_ff;
            alu_req.b   = k_ff;
            alu_req.sub = 1'b1;
            b_rd_addr   = cur_ff;
            if (k_ff == '0 || alu_res.carry) begin
               res_found_in = 1'b0;
               res_pos_in   = '0;
               state_in     = ST_Q_OUT;
            end else begin
               state_in = ST_Q_BKT;
            end
         end

         ST_Q_BKT: begin
            // One bucket count per cycle; the next read is already issued
            alu_req.a   = k_ff;
            alu_req.b   = {{(CNT_W-BCNT_W){1'b0}}, b_rd_data};
            alu_req.sub = 1'b1;
            b_rd_addr   = cur_ff + BKT_W'(1);
            if (alu_res.zero || alu_res.carry) begin
               state_in = ST_Q_ROW;
            end else begin
               k_in = alu_res.sum;
               if (cur_ff == {BKT_W{1'b1}}) begin
                  res_found_in = 1'b0;
                  res_pos_in   = '0;
                  state_in     = ST_Q_OUT;
               end else begin
                  cur_in = cur_ff + BKT_W'(1);
               end
            end
         end

         ST_Q_ROW: begin
            f_rd_addr = cur_ff;
            state_in  = ST_Q_LOAD;
         end

         ST_Q_LOAD: begin
            row_in   = f_rd_data;
            bit_in   = '0;
            state_in = ST_Q_BIT;
         end

         ST_Q_BIT: begin
            // One flag per cycle; stop where the remaining rank reaches zero
            alu_req.a   = k_ff;
            alu_req.b   = {{(CNT_W-1){1'b0}}, row_ff[0]};
            alu_req.sub = 1'b1;
            if (row_ff[0] && alu_res.zero) begin
               res_found_in = 1'b1;
               res_pos_in   = {cur_ff, bit_ff};
               state_in     = ST_Q_OUT;
            end else begin
               k_in   = alu_res.sum;
               row_in = row_ff >> 1;
               if (bit_ff == {BUCKET_SHIFT{1'b1}}) begin
                  res_found_in = 1'b0;
                  res_pos_in   = '0;
                  state_in     = ST_Q_OUT;
               end else begin
                  bit_in = bit_ff + BUCKET_SHIFT'(1);
               end
            end
         end

         ST_Q_OUT: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_pos_in   = res_pos_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_tready)
      else $error("request accepted during clearing pass");

   a_total_bounded: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(POSITIONS))
      else $error("singleton total above position count");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("answer position nonzero on a miss");

   a_row_rank_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_Q_ROW |-> k_ff != '0)
      else $error("bucket walk left no rank for the flag walk");

   a_bit_rank_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_Q_BIT |-> k_ff != '0)
      else $error("flag walk ran past the requested rank");
`endif

endmodule

`default_nettype wire
